FILE: design/tcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared types and constants for the timer channel with capture/compare.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int DATA_W = 32;
    localparam int CTRL_W = 9;

    // control/status bit positions
    localparam int CB_CAPMODE = 0;
    localparam int CB_DOWN    = 1;
    localparam int CB_GEN     = 2;
    localparam int CB_CAPEN   = 3;
    localparam int CB_ARELOAD = 4;
    localparam int CB_LOAD    = 5;
    localparam int CB_INTEN   = 6;
    localparam int CB_ENABLE  = 7;
    localparam int CB_FLAG    = 8;

    // request types
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // register addresses
    localparam logic [1:0] ADDR_CTRL  = 2'd0;
    localparam logic [1:0] ADDR_LOAD  = 2'd1;
    localparam logic [1:0] ADDR_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [1:0]        reg_addr;
        logic [DATA_W-1:0] write_data;
        logic              capture_line;
    } t_req;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq;
        logic              generate_pulse;
    } t_rsp;

endpackage
`default_nettype wire

FILE: design/tcc_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_req_if
// Request channel: tick, register write or register read.
// ----------------------------------------------------------------------------
interface tcc_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [1:0]  reg_addr;
    logic [31:0] write_data;
    logic        capture_line;

    modport source (output valid, output req_type, output reg_addr,
                    output write_data, output capture_line, input ready);
    modport sink   (input valid, input req_type, input reg_addr,
                    input write_data, input capture_line, output ready);
endinterface
`default_nettype wire

FILE: design/tcc_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_rsp_if
// Result channel: read data, interrupt and generate output.
// ----------------------------------------------------------------------------
interface tcc_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;
    logic        irq;
    logic        generate_pulse;

    modport source (output valid, output read_data, output irq,
                    output generate_pulse, input ready);
    modport sink   (input valid, input read_data, input irq,
                    input generate_pulse, output ready);
endinterface
`default_nettype wire

FILE: design/tcc_in_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_in_stage
// Input register: holds one request until the core takes it.
// ----------------------------------------------------------------------------
module tcc_in_stage (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tcc_req_if.sink          i_req,
    input  wire logic        i_take,
    output logic             o_valid,
    output tcc_pkg::t_req    o_req
);

    logic          r_valid;
    logic          n_valid;
    tcc_pkg::t_req r_req;
    logic          accept;

    assign i_req.ready = !r_valid || i_take;
    assign accept      = i_req.valid && i_req.ready;

    always_comb begin
        n_valid = r_valid;
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.req_type     <= i_req.req_type;
            r_req.reg_addr     <= i_req.reg_addr;
            r_req.write_data   <= i_req.write_data;
            r_req.capture_line <= i_req.capture_line;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule
`default_nettype wire

FILE: design/tcc_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_core
// Timer state (control, load, counter, capture line history) and the
// single-pass update for one request.
// ----------------------------------------------------------------------------
module tcc_core #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire tcc_pkg::t_req i_req,
    output tcc_pkg::t_rsp      o_rsp
);

    logic [tcc_pkg::CTRL_W-1:0] r_ctrl, n_ctrl;
    logic [COUNT_WIDTH-1:0]     r_load, n_load;
    logic [COUNT_WIDTH-1:0]     r_count, n_count;
    logic                       r_cap_prev, n_cap_prev;

    logic                       n_gen;
    logic [tcc_pkg::DATA_W-1:0] rd;
    logic                       rise;
    logic                       at_term;
    logic [COUNT_WIDTH-1:0]     count_step;

    assign rise       = i_req.capture_line && !r_cap_prev;
    assign at_term    = r_ctrl[tcc_pkg::CB_DOWN] ? (r_count == '0) : (r_count == '1);
    assign count_step = r_ctrl[tcc_pkg::CB_DOWN] ? (r_count - COUNT_WIDTH'(1))
                                                 : (r_count + COUNT_WIDTH'(1));

    always_comb begin
        n_ctrl     = r_ctrl;
        n_load     = r_load;
        n_count    = r_count;
        n_cap_prev = r_cap_prev;
        n_gen      = 1'b0;
        rd         = '0;
        if (i_fire) begin
            case (i_req.req_type)
                tcc_pkg::REQ_TICK: begin
                    n_cap_prev = i_req.capture_line;
                    if (r_ctrl[tcc_pkg::CB_LOAD]) begin
                        n_count = r_load;
                    end else if (r_ctrl[tcc_pkg::CB_ENABLE]) begin
                        if (r_ctrl[tcc_pkg::CB_CAPMODE]) begin
                            // earlier capture held while flag set without auto reload
                            if (rise && r_ctrl[tcc_pkg::CB_CAPEN] &&
                                !(r_ctrl[tcc_pkg::CB_FLAG] && !r_ctrl[tcc_pkg::CB_ARELOAD])) begin
                                n_load                  = r_count;
                                n_ctrl[tcc_pkg::CB_FLAG] = 1'b1;
                            end
                            n_count = count_step;
                        end else if (at_term) begin
                            n_ctrl[tcc_pkg::CB_FLAG] = 1'b1;
                            n_gen = r_ctrl[tcc_pkg::CB_GEN];
                            if (r_ctrl[tcc_pkg::CB_ARELOAD]) begin
                                n_count = r_load;
                            end
                        end else begin
                            n_count = count_step;
                        end
                    end
                end
                tcc_pkg::REQ_WRITE: begin
                    case (i_req.reg_addr)
                        tcc_pkg::ADDR_CTRL: begin
                            // flag is write-one-to-clear
                            n_ctrl = {r_ctrl[tcc_pkg::CB_FLAG] &&
                                      !i_req.write_data[tcc_pkg::CB_FLAG],
                                      i_req.write_data[tcc_pkg::CB_FLAG-1:0]};
                        end
                        tcc_pkg::ADDR_LOAD: begin
                            n_load = COUNT_WIDTH'(i_req.write_data);
                        end
                        default: ;
                    endcase
                end
                tcc_pkg::REQ_READ: begin
                    case (i_req.reg_addr)
                        tcc_pkg::ADDR_CTRL:  rd = tcc_pkg::DATA_W'(r_ctrl);
                        tcc_pkg::ADDR_LOAD:  rd = tcc_pkg::DATA_W'(r_load);
                        tcc_pkg::ADDR_COUNT: rd = tcc_pkg::DATA_W'(r_count);
                        default:             rd = '0;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl     <= '0;
            r_load     <= '0;
            r_count    <= '0;
            r_cap_prev <= 1'b0;
        end else begin
            r_ctrl     <= n_ctrl;
            r_load     <= n_load;
            r_count    <= n_count;
            r_cap_prev <= n_cap_prev;
        end
    end

    assign o_rsp.read_data      = rd;
    assign o_rsp.irq            = n_ctrl[tcc_pkg::CB_FLAG] && n_ctrl[tcc_pkg::CB_INTEN];
    assign o_rsp.generate_pulse = n_gen;

`ifndef SYNTHESIS
    a_gen_compare_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && n_gen) |-> (!r_ctrl[tcc_pkg::CB_CAPMODE] && r_ctrl[tcc_pkg::CB_ENABLE]
                               && !r_ctrl[tcc_pkg::CB_LOAD] && at_term))
        else $error("generate pulse outside a compare terminal count");

    a_read_no_side_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == tcc_pkg::REQ_READ)
        |=> ($stable(r_ctrl) && $stable(r_load) && $stable(r_count)))
        else $error("read request changed timer state");

    a_flag_clear_by_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_ctrl[tcc_pkg::CB_FLAG]) |->
        $past(i_fire && i_req.req_type == tcc_pkg::REQ_WRITE &&
              i_req.reg_addr == tcc_pkg::ADDR_CTRL && i_req.write_data[tcc_pkg::CB_FLAG]))
        else $error("interrupt flag cleared without a control write");

    a_disabled_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == tcc_pkg::REQ_TICK && !r_ctrl[tcc_pkg::CB_LOAD]
         && !r_ctrl[tcc_pkg::CB_ENABLE]) |=> ($stable(r_count) && $stable(r_load)))
        else $error("disabled timer moved on a tick");
`endif

endmodule
`default_nettype wire

FILE: design/tcc_out_stage.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcc_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tcc_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tcc_pkg::t_rsp i_rsp,
    output logic               o_ready,
    tcc_rsp_if.source          o_rsp
);

    logic          r_valid;
    logic          n_valid;
    tcc_pkg::t_rsp r_rsp;
    logic          load;

    assign o_ready = !r_valid || o_rsp.ready;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (o_rsp.ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rsp <= i_rsp;
        end
    end

    assign o_rsp.valid          = r_valid;
    assign o_rsp.read_data      = r_rsp.read_data;
    assign o_rsp.irq            = r_rsp.irq;
    assign o_rsp.generate_pulse = r_rsp.generate_pulse;

endmodule
`default_nettype wire

FILE: design/timer_counter_capture_compare.sv
`default_nettype none
// ----------------------------------------------------------------------------
// timer_counter_capture_compare
// One timer channel with capture/compare behind a request/result channel.
// ----------------------------------------------------------------------------
// Each request (tick, register write or register read) gives one result.
// Throughput is one request per cycle while the result side is not stalled;
// each request passes the input register, then the state update and result register.
// The timer state is updated in the single core stage, so a tick, write or
// read sees everything that went before it. The counter is COUNT_WIDTH bits;
// reads return its low 32 bits and writes to the load register zero-extend
// or truncate to COUNT_WIDTH.
module timer_counter_capture_compare #(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    tcc_req_if.sink   i_req,
    tcc_rsp_if.source o_rsp
);

    logic          in_valid;
    tcc_pkg::t_req in_req;
    logic          out_ready;
    logic          fire;
    tcc_pkg::t_rsp core_rsp;

    assign fire = in_valid && out_ready;

    tcc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_take  (fire),
        .o_valid (in_valid),
        .o_req   (in_req)
    );

    tcc_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (in_req),
        .o_rsp   (core_rsp)
    );

    tcc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .i_rsp   (core_rsp),
        .o_ready (out_ready),
        .o_rsp   (o_rsp)
    );

endmodule
`default_nettype wire

FILE: bench/timer_counter_capture_compare_tb.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timer_counter_capture_compare_tb
// Self-checking bench for the timer channel: ticks, register writes and reads
// are driven through the request channel and every result is compared with a
// cycle-free prediction of the timer state, under varying back-pressure.
// ----------------------------------------------------------------------------
module timer_counter_capture_compare_tb;

    localparam logic [1:0] REQ_NONE  = 2'd3;   // undefined request type
    localparam logic [1:0] ADDR_NONE = 2'd3;   // unmapped address

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 2000;
    localparam int PHASE_LEN    = 300;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 200000;

    logic i_clk;
    logic i_rst_n;

    tcc_req_if req_if ();
    tcc_rsp_if rsp_if ();

    timer_counter_capture_compare i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // predicted timer state
    logic [tcc_pkg::CTRL_W-1:0] ctrl_bits;
    logic [tcc_pkg::DATA_W-1:0] load_val;
    logic [tcc_pkg::DATA_W-1:0] count_val;
    logic                       cap_prev;

    tcc_pkg::t_req request_queue[$];
    tcc_pkg::t_rsp pending_results[$];
    tcc_pkg::t_req next_req;
    tcc_pkg::t_req seen_req;
    tcc_pkg::t_rsp exp_rsp;

    int  accepted_cnt = 0;
    int  total_items  = 0;
    int  fail_cnt     = 0;
    int  cycle_cnt    = 0;
    int  send_idle_pct;
    int  recv_stall_pct;
    bit  req_fire     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Applies one request to the predicted state and returns its result.
    function automatic tcc_pkg::t_rsp timer_step(tcc_pkg::t_req r);
        tcc_pkg::t_rsp              res;
        logic [tcc_pkg::CTRL_W-1:0] cb;
        logic [tcc_pkg::DATA_W-1:0] terminal;
        logic                       rise;
        res = '0;
        case (r.req_type)
            tcc_pkg::REQ_TICK: begin
                cb       = ctrl_bits;
                rise     = r.capture_line && !cap_prev;
                cap_prev = r.capture_line;
                if (cb[tcc_pkg::CB_LOAD]) begin
                    count_val = load_val;
                end else if (cb[tcc_pkg::CB_ENABLE]) begin
                    if (cb[tcc_pkg::CB_CAPMODE]) begin
                        // an earlier capture is held while the flag is up without reload
                        if (rise && cb[tcc_pkg::CB_CAPEN] &&
                            !(cb[tcc_pkg::CB_FLAG] && !cb[tcc_pkg::CB_ARELOAD])) begin
                            load_val                    = count_val;
                            ctrl_bits[tcc_pkg::CB_FLAG] = 1'b1;
                        end
                        count_val = cb[tcc_pkg::CB_DOWN] ? count_val - 32'd1
                                                         : count_val + 32'd1;
                    end else begin
                        terminal = cb[tcc_pkg::CB_DOWN] ? {tcc_pkg::DATA_W{1'b0}}
                                                        : {tcc_pkg::DATA_W{1'b1}};
                        if (count_val == terminal) begin
                            ctrl_bits[tcc_pkg::CB_FLAG] = 1'b1;
                            res.generate_pulse = cb[tcc_pkg::CB_GEN];
                            if (cb[tcc_pkg::CB_ARELOAD])
                                count_val = load_val;
                        end else if (cb[tcc_pkg::CB_DOWN]) begin
                            count_val = count_val - 32'd1;
                        end else begin
                            count_val = count_val + 32'd1;
                        end
                    end
                end
            end
            tcc_pkg::REQ_WRITE: begin
                if (r.reg_addr == tcc_pkg::ADDR_CTRL) begin
                    ctrl_bits = {ctrl_bits[tcc_pkg::CB_FLAG] && !r.write_data[tcc_pkg::CB_FLAG],
                                 r.write_data[7:0]};
                end else if (r.reg_addr == tcc_pkg::ADDR_LOAD) begin
                    load_val = r.write_data;
                end
            end
            tcc_pkg::REQ_READ: begin
                if (r.reg_addr == tcc_pkg::ADDR_CTRL)
                    res.read_data = {{(tcc_pkg::DATA_W-tcc_pkg::CTRL_W){1'b0}}, ctrl_bits};
                else if (r.reg_addr == tcc_pkg::ADDR_LOAD)
                    res.read_data = load_val;
                else if (r.reg_addr == tcc_pkg::ADDR_COUNT)
                    res.read_data = count_val;
            end
            default: ;
        endcase
        res.irq = ctrl_bits[tcc_pkg::CB_FLAG] && ctrl_bits[tcc_pkg::CB_INTEN];
        return res;
    endfunction

    task automatic push_req(input logic [1:0] rt, input logic [1:0] addr,
                            input logic [31:0] wd, input logic line);
        tcc_pkg::t_req r;
        r.req_type     = rt;
        r.reg_addr     = addr;
        r.write_data   = wd;
        r.capture_line = line;
        request_queue.push_back(r);
    endtask

    // Driver: requests and result back-pressure change on the falling edge.
    always @(negedge i_clk) begin
        case ((accepted_cnt / PHASE_LEN) % 4)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
        endcase
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            rsp_if.ready <= 1'b0;
        end else begin
            if (!req_if.valid || req_fire) begin
                if (request_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    next_req = request_queue.pop_front();
                    req_if.valid        <= 1'b1;
                    req_if.req_type     <= next_req.req_type;
                    req_if.reg_addr     <= next_req.reg_addr;
                    req_if.write_data   <= next_req.write_data;
                    req_if.capture_line <= next_req.capture_line;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
            rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor: accepted requests are predicted, accepted results checked.
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("** timer_counter_capture_compare: FAILED **");
            $finish;
        end else begin
            req_fire = i_rst_n && req_if.valid && req_if.ready;
            if (req_fire) begin
                seen_req.req_type     = req_if.req_type;
                seen_req.reg_addr     = req_if.reg_addr;
                seen_req.write_data   = req_if.write_data;
                seen_req.capture_line = req_if.capture_line;
                pending_results.push_back(timer_step(seen_req));
                accepted_cnt++;
            end
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result: expected none, got data %h irq %b gen %b",
                             $time, rsp_if.read_data, rsp_if.irq, rsp_if.generate_pulse);
                    fail_cnt++;
                end else begin
                    exp_rsp = pending_results.pop_front();
                    if (rsp_if.read_data !== exp_rsp.read_data) begin
                        $display("%0t: read_data mismatch: expected %h, got %h",
                                 $time, exp_rsp.read_data, rsp_if.read_data);
                        fail_cnt++;
                    end
                    if (rsp_if.irq !== exp_rsp.irq) begin
                        $display("%0t: irq mismatch: expected %b, got %b",
                                 $time, exp_rsp.irq, rsp_if.irq);
                        fail_cnt++;
                    end
                    if (rsp_if.generate_pulse !== exp_rsp.generate_pulse) begin
                        $display("%0t: generate_pulse mismatch: expected %b, got %b",
                                 $time, exp_rsp.generate_pulse, rsp_if.generate_pulse);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] wd;
        int          n_ticks;
        int          target;

        i_rst_n             = 1'b0;
        req_if.valid        = 1'b0;
        req_if.req_type     = tcc_pkg::REQ_TICK;
        req_if.reg_addr     = tcc_pkg::ADDR_CTRL;
        req_if.write_data   = '0;
        req_if.capture_line = 1'b0;
        rsp_if.ready        = 1'b0;
        ctrl_bits           = '0;
        load_val            = '0;
        count_val           = '0;
        cap_prev            = 1'b0;

        // up-count compare: terminal hit, then hold at the terminal count with repeat
        push_req(tcc_pkg::REQ_READ,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_LOAD, 32'hFFFF_FFFF, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'hFFFF_FE20, 1'b0);  // load bit
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b1);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'h0000_00C4, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_READ,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        // down-count compare to zero with auto reload
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_LOAD, 32'h0000_0001, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'h0000_0120, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'h0000_00D6, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_COUNT, 32'h5A5A_5A5A, 1'b0);  // read-only
        push_req(tcc_pkg::REQ_READ,  tcc_pkg::ADDR_COUNT, 32'h0, 1'b0);
        push_req(REQ_NONE,           tcc_pkg::ADDR_LOAD, 32'hFFFF_FFFF, 1'b1);
        // capture: first edge taken, second held while flag is up
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'h0000_01C9, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b1);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b1);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b1);
        push_req(tcc_pkg::REQ_READ,  tcc_pkg::ADDR_LOAD, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_WRITE, ADDR_NONE, 32'hFFFF_FFFF, 1'b0);
        push_req(tcc_pkg::REQ_READ,  ADDR_NONE, 32'h0, 1'b0);
        // timer disabled: counter holds, edge ignored
        push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, 32'h0000_0009, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b0);
        push_req(tcc_pkg::REQ_TICK,  tcc_pkg::ADDR_CTRL, 32'h0, 1'b1);
        push_req(tcc_pkg::REQ_READ,  tcc_pkg::ADDR_COUNT, 32'h0, 1'b0);

        // random part: mostly load / configure / run sequences, some noise
        target = request_queue.size() + RANDOM_ITEMS;
        while (request_queue.size() < target) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 4))
                    push_req(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                             $urandom(), 1'($urandom_range(0, 1)));
            end else begin
                // load values near the terminal counts so compares actually fire
                case ($urandom_range(0, 3))
                    0:       wd = $urandom_range(0, 8);
                    1:       wd = 32'hFFFF_FFFF - $urandom_range(0, 8);
                    default: wd = $urandom();
                endcase
                push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_LOAD, wd, 1'($urandom_range(0, 1)));
                wd = $urandom();
                wd[tcc_pkg::CB_LOAD] = 1'b1;
                push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, wd, 1'($urandom_range(0, 1)));
                push_req(tcc_pkg::REQ_TICK, tcc_pkg::ADDR_CTRL, $urandom(),
                         1'($urandom_range(0, 1)));
                wd = $urandom();
                wd[tcc_pkg::CB_LOAD]   = ($urandom_range(0, 9) == 0);
                wd[tcc_pkg::CB_ENABLE] = ($urandom_range(0, 9) != 0);
                push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, wd, 1'($urandom_range(0, 1)));
                n_ticks = $urandom_range(1, 12);
                repeat (n_ticks) begin
                    push_req(tcc_pkg::REQ_TICK, 2'($urandom_range(0, 3)), $urandom(),
                             1'($urandom_range(0, 1)));
                    case ($urandom_range(0, 19))
                        0, 1, 2: push_req(tcc_pkg::REQ_READ, 2'($urandom_range(0, 2)),
                                          $urandom(), 1'($urandom_range(0, 1)));
                        3: begin
                            // mid-run reconfigure, often clearing the flag
                            wd = $urandom();
                            wd[tcc_pkg::CB_LOAD]   = 1'b0;
                            wd[tcc_pkg::CB_ENABLE] = 1'b1;
                            push_req(tcc_pkg::REQ_WRITE, tcc_pkg::ADDR_CTRL, wd,
                                     1'($urandom_range(0, 1)));
                        end
                        default: ;
                    endcase
                end
            end
        end
        total_items = request_queue.size();

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_cnt < total_items || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_cnt == 0) begin
            $display("** timer_counter_capture_compare: PASSED **");
        end else begin
            $display("** timer_counter_capture_compare: FAILED **");
        end
        $finish;
    end

endmodule
`default_nettype wire
